// File: hdl/alpha_blend_scaled_blitter_macros.svh
// Assertion helpers.
`ifndef ALPHA_BLEND_SCALED_BLITTER_MACROS_SVH
`define ALPHA_BLEND_SCALED_BLITTER_MACROS_SVH
`ifndef SYNTHESIS
`define ABSB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ABSB_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABSB_ASSERT(label, clk, rst, prop, msg)
`define ABSB_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: hdl/absb_pkg.sv
package absb_pkg;
   localparam int FB_WIDTH_DEF   = 256;
   localparam int FB_HEIGHT_DEF  = 192;
   localparam int SRC_TEXELS_DEF = 4096;

   localparam logic [2:0] CMD_CLEAR   = 3'd0;
   localparam logic [2:0] CMD_OVERLAY = 3'd1;
   localparam logic [2:0] CMD_LOAD    = 3'd2;
   localparam logic [2:0] CMD_DRAW    = 3'd3;
   localparam logic [2:0] CMD_READ    = 3'd4;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } rgba_type;

   // (c*a + d*(255-a)) / 255, sum < 65536; reciprocal with one correction
   function automatic logic [7:0] blend8(input logic [7:0] c, input logic [7:0] d,
                                         input logic [7:0] a);
      logic [15:0] s;
      logic [16:0] q;
      logic [16:0] rem;
      s = 16'(c * a) + 16'(d * (8'd255 - a));
      q = 17'((33'(s) * 33'd257) >> 16);
      rem = 17'(s) - 17'(q * 17'd255);
      if (rem >= 17'd255) q = q + 17'd1;
      return q[7:0];
   endfunction
endpackage

// File: hdl/alpha_blend_scaled_blitter.sv
// Scaled alpha blitter over an RGBA8 frame store.
// req_* carries one command item; rsp_* returns one item per pixel read.
// Load texel: written on accept. Read pixel: result via the frame read
// register, then the response register, no new item taken meanwhile; a
// read beyond the frame answers zero via the response register alone.
// Clear and overlay (nonzero alpha only) walk the whole frame, one pixel
// per cycle through the frame memory read-modify-write pipe. Draw walks
// the clipped rectangle; the divider maps each row and each pixel to the
// source, then the texel is read and, unless its alpha is zero, blended in.
// Reset: after reset release a clearing pass zeroes the frame memory,
// req_tready low meanwhile. Texel memory is not cleared. A stalled
// rsp_tready holds the result and blocks further items.
module alpha_blend_scaled_blitter #(
   parameter int FB_WIDTH   = absb_pkg::FB_WIDTH_DEF,
   parameter int FB_HEIGHT  = absb_pkg::FB_HEIGHT_DEF,
   parameter int SRC_TEXELS = absb_pkg::SRC_TEXELS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[2:0] red[10:3] green[18:11] blue[26:19] alpha[34:27] address[50:35]
   // src_width[57:51] src_height[64:58] dest_x[75:65] dest_y[86:76]
   // dest_width[96:87] dest_height[106:97], zero to 111
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pixel_red[7:0] pixel_green[15:8] pixel_blue[23:16] pixel_alpha[31:24]
   output logic [31:0]  rsp_tdata
);
   import absb_pkg::*;
`include "alpha_blend_scaled_blitter_macros.svh"

   localparam int FbPixels = FB_WIDTH * FB_HEIGHT;
   localparam int FaW = (FbPixels > 1) ? $clog2(FbPixels) : 1;
   localparam int TaW = (SRC_TEXELS > 1) ? $clog2(SRC_TEXELS) : 1;

   localparam logic [3:0] ST_CLR0  = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_FILL  = 4'd2;
   localparam logic [3:0] ST_DRAIN = 4'd3;
   localparam logic [3:0] ST_ROW   = 4'd4;
   localparam logic [3:0] ST_ROWW  = 4'd5;
   localparam logic [3:0] ST_COL   = 4'd6;
   localparam logic [3:0] ST_COLW  = 4'd7;
   localparam logic [3:0] ST_TEX   = 4'd8;
   localparam logic [3:0] ST_TEXW  = 4'd9;
   localparam logic [3:0] ST_PIX   = 4'd10;
   localparam logic [3:0] ST_PIXW  = 4'd11;
   localparam logic [3:0] ST_READ  = 4'd12;

   logic [31:0] fmem [FbPixels];
   logic [31:0] tmem [SRC_TEXELS];

   logic [2:0]  f_cmd;
   logic [7:0]  f_r, f_g, f_b, f_a;
   logic [15:0] f_addr;
   logic [6:0]  f_sw, f_sh;
   logic signed [10:0] f_x, f_y;
   logic [9:0]  f_dw, f_dh;
   assign f_cmd = req_tdata[2:0];
   assign f_r = req_tdata[10:3];
   assign f_g = req_tdata[18:11];
   assign f_b = req_tdata[26:19];
   assign f_a = req_tdata[34:27];
   assign f_addr = req_tdata[50:35];
   assign f_sw = req_tdata[57:51];
   assign f_sh = req_tdata[64:58];
   assign f_x = req_tdata[75:65];
   assign f_y = req_tdata[86:76];
   assign f_dw = req_tdata[96:87];
   assign f_dh = req_tdata[106:97];

   logic [3:0]  st_ff, st_in;
   logic [FaW:0] sweep_ff, sweep_in;
   logic        ovl_ff, ovl_in;
   rgba_type    col_ff, col_in;
   logic [6:0]  sw_ff, sw_in, sh_ff, sh_in;
   logic [9:0]  dw_ff, dw_in, dh_ff, dh_in;
   logic signed [11:0] x_ff, x_in, y_ff, y_in;
   logic [10:0] i_ff, i_in, j_ff, j_in, i0_ff, i0_in, i1_ff, i1_in;
   logic [9:0]  sy_ff, sy_in;
   logic [31:0] tex_ff, tex_in;
   logic [FaW-1:0] di_ff, di_in;
   logic        rsp_v_ff, rsp_v_in;
   logic [31:0] rsp_d_ff, rsp_d_in;

   logic        f_re, f_we;
   logic [FaW-1:0] f_ra, f_wa;
   logic [31:0] f_rd, f_wd;
   logic        t_re;
   logic [TaW-1:0] t_ra;
   logic [31:0] t_rd;

   logic        p1_v_ff, p1_v_in;
   logic [FaW-1:0] p1_a_ff, p1_a_in;

   logic        dv_start, dv_done;
   logic [16:0] dv_n;
   logic [9:0]  dv_d, dv_q;

   absb_divider u_div (.clock(clock), .reset(reset), .start(dv_start), .numer(dv_n),
                       .denom(dv_d), .done(dv_done), .quot(dv_q));

   logic        acc;
   assign req_tready = (st_ff == ST_IDLE) && !(rsp_v_ff && !rsp_tready);
   assign acc = req_tvalid && req_tready;

   function automatic logic [31:0] fill_px(input logic ovl, input rgba_type c,
                                           input logic [31:0] d);
      logic [31:0] o;
      if (!ovl) o = {c.a, c.b, c.g, c.r};
      else o = {8'd255, blend8(c.b, d[23:16], c.a), blend8(c.g, d[15:8], c.a),
                blend8(c.r, d[7:0], c.a)};
      return o;
   endfunction

   logic signed [12:0] lim;
   logic [17:0] ti_w;
   logic [20:0] di_w;
   logic [11:0] ry, rx;

   always_comb begin
      st_in = st_ff; sweep_in = sweep_ff; ovl_in = ovl_ff; col_in = col_ff;
      sw_in = sw_ff; sh_in = sh_ff; dw_in = dw_ff; dh_in = dh_ff;
      x_in = x_ff; y_in = y_ff; i_in = i_ff; j_in = j_ff; i0_in = i0_ff;
      i1_in = i1_ff; sy_in = sy_ff; tex_in = tex_ff; di_in = di_ff;
      rsp_v_in = rsp_v_ff && !rsp_tready; rsp_d_in = rsp_d_ff;
      f_re = 1'b0; f_ra = '0; f_we = 1'b0; f_wa = '0; f_wd = '0;
      t_re = 1'b0; t_ra = '0;
      p1_v_in = 1'b0; p1_a_in = '0;
      dv_start = 1'b0; dv_n = '0; dv_d = 10'd1;
      lim = '0; ti_w = '0; di_w = '0; ry = '0; rx = '0;
      case (st_ff)
         ST_CLR0: begin
            f_we = 1'b1; f_wa = sweep_ff[FaW-1:0];
            if (32'(sweep_ff) == FbPixels - 1) st_in = ST_IDLE;
            else sweep_in = sweep_ff + 1'b1;
         end
         ST_IDLE: begin
            if (acc) begin
               col_in = '{r: f_r, g: f_g, b: f_b, a: f_a};
               case (f_cmd)
                  CMD_CLEAR: begin
                     ovl_in = 1'b0; sweep_in = '0; st_in = ST_FILL;
                  end
                  CMD_OVERLAY: begin
                     if (f_a != 8'd0) begin
                        ovl_in = 1'b1; sweep_in = '0; st_in = ST_FILL;
                     end
                  end
                  CMD_LOAD: ;
                  CMD_READ: begin
                     if (32'(f_addr) < FbPixels) begin
                        f_re = 1'b1; f_ra = FaW'(f_addr);
                        st_in = ST_READ;
                     end else begin
                        rsp_v_in = 1'b1; rsp_d_in = '0;
                     end
                  end
                  CMD_DRAW: begin
                     if (f_sw != 7'd0 && f_sh != 7'd0) begin
                        sw_in = f_sw; sh_in = f_sh;
                        dw_in = (f_dw == 10'd0) ? 10'(f_sw) : f_dw;
                        dh_in = (f_dh == 10'd0) ? 10'(f_sh) : f_dh;
                        x_in = 12'(f_x); y_in = 12'(f_y);
                        j_in = (f_y < 0) ? 11'(-12'(f_y)) : 11'd0;
                        i0_in = (f_x < 0) ? 11'(-12'(f_x)) : 11'd0;
                        st_in = ST_ROW;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            rsp_v_in = 1'b1; rsp_d_in = f_rd; st_in = ST_IDLE;
         end
         ST_FILL: begin
            f_re = 1'b1; f_ra = sweep_ff[FaW-1:0];
            p1_v_in = 1'b1; p1_a_in = sweep_ff[FaW-1:0];
            if (32'(sweep_ff) == FbPixels - 1) st_in = ST_DRAIN;
            else sweep_in = sweep_ff + 1'b1;
         end
         ST_DRAIN: begin
            if (!p1_v_ff) st_in = ST_IDLE;
         end
         ST_ROW: begin
            lim = 13'(FB_WIDTH) - 13'(x_ff);
            if (lim > $signed({3'b0, dw_ff})) lim = $signed({3'b0, dw_ff});
            i1_in = (lim < 13'sd0) ? 11'd0 : 11'(lim);
            lim = 13'(FB_HEIGHT) - 13'(y_ff);
            if (lim > $signed({3'b0, dh_ff})) lim = $signed({3'b0, dh_ff});
            if (lim <= $signed({2'b0, j_ff})) begin
               st_in = ST_IDLE;
            end else begin
               i_in = i0_ff;
               dv_start = 1'b1; dv_n = 17'(j_ff * sh_ff); dv_d = dh_ff;
               st_in = ST_ROWW;
            end
         end
         ST_ROWW: begin
            dv_d = dh_ff;
            if (dv_done) begin
               sy_in = dv_q; st_in = ST_COL;
            end
         end
         ST_COL: begin
            if (i_ff >= i1_ff) begin
               j_in = j_ff + 11'd1; st_in = ST_ROW;
            end else begin
               dv_start = 1'b1; dv_n = 17'(i_ff * sw_ff); dv_d = dw_ff;
               st_in = ST_COLW;
            end
         end
         ST_COLW: begin
            dv_d = dw_ff;
            if (dv_done) begin
               ti_w = 18'(sy_ff * sw_ff) + 18'(dv_q);
               ry = 12'(y_ff + $signed({1'b0, j_ff}));
               rx = 12'(x_ff + $signed({1'b0, i_ff}));
               di_w = 21'(ry) * 21'(FB_WIDTH) + 21'(rx);
               di_in = FaW'(di_w);
               if (32'(ti_w) < SRC_TEXELS && 32'(di_w) < FbPixels) begin
                  t_re = 1'b1; t_ra = TaW'(ti_w); st_in = ST_TEX;
               end else begin
                  i_in = i_ff + 11'd1; st_in = ST_COL;
               end
            end
         end
         ST_TEX: begin
            tex_in = t_rd;
            if (t_rd[31:24] == 8'd0) begin
               i_in = i_ff + 11'd1; st_in = ST_COL;
            end else begin
               f_re = 1'b1; f_ra = di_ff; st_in = ST_PIX;
            end
         end
         ST_PIX: begin
            f_we = 1'b1; f_wa = di_ff;
            if (tex_ff[31:24] == 8'd255) f_wd = {8'd255, tex_ff[23:0]};
            else f_wd = {8'd255, blend8(tex_ff[23:16], f_rd[23:16], tex_ff[31:24]),
                         blend8(tex_ff[15:8], f_rd[15:8], tex_ff[31:24]),
                         blend8(tex_ff[7:0], f_rd[7:0], tex_ff[31:24])};
            i_in = i_ff + 11'd1; st_in = ST_COL;
         end
         default: st_in = ST_IDLE;
      endcase
      if (p1_v_ff) begin
         f_we = 1'b1; f_wa = p1_a_ff; f_wd = fill_px(ovl_ff, col_ff, f_rd);
      end
   end

   always_ff @(posedge clock) begin
      if (f_re) f_rd <= fmem[f_ra];
      if (f_we) fmem[f_wa] <= f_wd;
      if (t_re) t_rd <= tmem[t_ra];
      if (acc && f_cmd == CMD_LOAD && 32'(f_addr) < SRC_TEXELS)
         tmem[TaW'(f_addr)] <= {f_a, f_b, f_g, f_r};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLR0;
         sweep_ff <= '0;
         rsp_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         sweep_ff <= sweep_in;
         rsp_v_ff <= rsp_v_in;
         p1_v_ff <= p1_v_in;
      end
      p1_a_ff <= p1_a_in; ovl_ff <= ovl_in; col_ff <= col_in;
      sw_ff <= sw_in; sh_ff <= sh_in; dw_ff <= dw_in; dh_ff <= dh_in;
      x_ff <= x_in; y_ff <= y_in; i_ff <= i_in; j_ff <= j_in; i0_ff <= i0_in;
      i1_ff <= i1_in; sy_ff <= sy_in; tex_ff <= tex_in; di_ff <= di_in;
      rsp_d_ff <= rsp_d_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = rsp_d_ff;

   `ABSB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped")
   `ABSB_ASSERT(a_no_acc_busy, clock, reset, st_ff != ST_IDLE |-> !req_tready, "accept while busy")
   `ABSB_ASSERT(a_fill_wb, clock, reset, st_ff == ST_FILL |=> p1_v_ff, "fill writeback missing")
   `ABSB_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_tvalid && !req_tready, "reset state")
endmodule

// File: hdl/absb_divider.sv
// Restoring divider, 10-bit quotient of n / d, one bit a cycle.
module absb_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] numer,
   input  logic [9:0]  denom,
   output logic        done,
   output logic [9:0]  quot
);
   logic [16:0] rem_ff, rem_in;
   logic [9:0]  q_ff, q_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [26:0] trial;

   always_comb begin
      rem_in = rem_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = 27'(denom) << cnt_ff;
      if (start) begin
         rem_in = numer;
         q_in = '0;
         cnt_in = 4'd9;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (27'(rem_ff) >= trial) begin
            rem_in = 17'(27'(rem_ff) - trial);
            q_in[cnt_ff] = 1'b1;
         end
         if (cnt_ff == 4'd0) busy_in = 1'b0;
         else cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
   end

   assign done = busy_ff && !busy_in;
   assign quot = q_in;
endmodule
